// ----- rtl/squared_gaussian_illumination_defines.svh -----
// Assertion macros shared by the illumination block.
`ifndef SQUARED_GAUSSIAN_ILLUMINATION_DEFINES_SVH
`define SQUARED_GAUSSIAN_ILLUMINATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SGI_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("illumination check failed");
// Next-cycle implication.
`define SGI_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("illumination check failed");
`else
`define SGI_ASSERT_IMPLY(name, clk, rst, pre, post)
`define SGI_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

// ----- rtl/sgi_pkg.sv -----
`default_nettype none
package sgi_pkg;

   // Control that travels with each item down the pipeline
   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [5:0] n;
   } sgi_ctrl_type;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_AMPLITUDE  = 2'd0,
      REG_INV_WIDTH2 = 2'd1,
      REG_CENTER_X   = 2'd2,
      REG_CENTER_Y   = 2'd3
   } sgi_reg_type;

   localparam logic signed [31:0] AMPLITUDE_RESET  = 32'sd65536;
   localparam logic [31:0]        INV_WIDTH2_RESET = 32'd55461871;
   localparam logic [23:0]        CENTER_RESET     = 24'd0;

   localparam logic [60:0] ONE_Q60   = 61'h1000000000000000;
   localparam logic [55:0] LN2_Q56   = 56'hB17217F7D1CF7A;
   // log2(e) in Q.32, rounded down far enough that the quotient estimate never overshoots
   localparam logic [32:0] LOG2E_Q32 = 33'd6196328000;
   localparam logic [49:0] X_LIMIT   = 50'd1073741824;
   localparam logic [6:0]  N_LIMIT   = 7'd61;
   localparam int          TAYLOR_TERMS = 20;

endpackage
`default_nettype wire

// ----- rtl/sgi_term.sv -----
`default_nettype none
module sgi_term import sgi_pkg::*; #(
   parameter int IDX = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  sgi_ctrl_type ctrl_in,
   input  logic [60:0]  term_in,
   input  logic [60:0]  sum_in,
   input  logic [59:0]  f_in,
   output sgi_ctrl_type ctrl_out,
   output logic [60:0]  term_out,
   output logic [60:0]  sum_out,
   output logic [59:0]  f_out
);

   localparam bit FIRST    = (IDX == 1);
   localparam bit SUBTRACT = (((IDX - 1) % 2) == 1);
   localparam bit POW2     = ((IDX & (IDX - 1)) == 0);
   localparam int SHIFT    = $clog2(IDX);
   localparam logic [65:0] RECIP_W = ((66'd1 << 65) + 66'(IDX) - 66'd1) / 66'(IDX);
   localparam logic [63:0] RECIP   = RECIP_W[63:0];

   sgi_ctrl_type c1_ff, c2_ff, c3_ff, c4_ff;
   logic [59:0]  f1_ff, f2_ff, f3_ff, f4_ff;
   logic [60:0]  sum1_ff, sum2_ff, sum3_ff, sum4_ff;
   logic [60:0]  sum1_in;
   logic [56:0]  p_hh_ff;
   logic [60:0]  p_hl_ff;
   logic [59:0]  p_lh_ff;
   logic [63:0]  p_ll_ff;
   logic [120:0] full_in;
   logic [59:0]  q2_ff;

   // Fold the previous term into the running sum
   always_comb begin
      if (FIRST) begin
         sum1_in = sum_in;
      end else if (SUBTRACT) begin
         sum1_in = sum_in - term_in;
      end else begin
         sum1_in = sum_in + term_in;
      end
   end

   // Advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
      end else if (advance) begin
         c1_ff <= ctrl_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
      end
   end

   // Stage 1: partial products of term times f; stage 2: sum and drop 60 bits
   assign full_in = 121'({p_hh_ff, 64'd0}) + 121'({p_hl_ff, 32'd0})
                  + 121'({p_lh_ff, 32'd0}) + 121'(p_ll_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         p_hh_ff <= term_in[60:32] * f_in[59:32];
         p_hl_ff <= term_in[60:32] * f_in[31:0];
         p_lh_ff <= f_in[59:32] * term_in[31:0];
         p_ll_ff <= term_in[31:0] * f_in[31:0];
         sum1_ff <= sum1_in;
         f1_ff   <= f_in;
         q2_ff   <= full_in[119:60];
         sum2_ff <= sum1_ff;
         f2_ff   <= f1_ff;
         sum3_ff <= sum2_ff;
         f3_ff   <= f2_ff;
         sum4_ff <= sum3_ff;
         f4_ff   <= f3_ff;
      end
   end

   // Stages 3 and 4: divide by the term index
   generate
      if (POW2) begin : g_shift
         logic [59:0] q3_ff;
         logic [60:0] t4_ff;
         always_ff @(posedge clock) begin
            if (advance) begin
               q3_ff <= q2_ff;
               t4_ff <= 61'(q3_ff >> SHIFT);
            end
         end
         assign term_out = t4_ff;
      end else begin : g_recip
         logic [61:0]  d_hh_ff, d_hl_ff, d_lh_ff, d_ll_ff;
         logic [125:0] full2_in;
         logic [60:0]  t4_ff;
         // quotient splits at bit 30, reciprocal at bit 32
         assign full2_in = 126'({d_hh_ff, 62'd0}) + 126'({d_hl_ff, 30'd0})
                         + 126'({d_lh_ff, 32'd0}) + 126'(d_ll_ff);
         always_ff @(posedge clock) begin
            if (advance) begin
               d_hh_ff <= q2_ff[59:30] * RECIP[63:32];
               d_hl_ff <= q2_ff[59:30] * RECIP[31:0];
               d_lh_ff <= q2_ff[29:0] * RECIP[63:32];
               d_ll_ff <= q2_ff[29:0] * RECIP[31:0];
               t4_ff   <= 61'(full2_in[123:65]);
            end
         end
         assign term_out = t4_ff;
      end
   endgenerate

   assign ctrl_out = c4_ff;
   assign sum_out  = sum4_ff;
   assign f_out    = f4_ff;

endmodule
`default_nettype wire

// ----- rtl/sgi_root.sv -----
`default_nettype none
module sgi_root import sgi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  sgi_ctrl_type ctrl_in,
   input  logic [60:0]  h_in,
   output sgi_ctrl_type ctrl_out,
   output logic [30:0]  root_out
);

   localparam int STEPS = 32;

   logic [63:0]  v_ff   [STEPS];
   logic [63:0]  res_ff [STEPS];
   sgi_ctrl_type c_ff   [STEPS];
   logic [63:0]  v_src  [STEPS];
   logic [63:0]  res_src[STEPS];
   sgi_ctrl_type c_src  [STEPS];

   assign v_src[0]   = 64'(h_in);
   assign res_src[0] = '0;
   assign c_src[0]   = ctrl_in;

   // One restoring square-root step per stage
   generate
      for (genvar k = 0; k < STEPS; k++) begin : g_step
         localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
         logic [63:0] trial;
         logic [63:0] v_in;
         logic [63:0] res_in;

         if (k > 0) begin : g_link
            assign v_src[k]   = v_ff[k-1];
            assign res_src[k] = res_ff[k-1];
            assign c_src[k]   = c_ff[k-1];
         end

         assign trial = res_src[k] + BIT;

         always_comb begin
            if (v_src[k] >= trial) begin
               v_in   = v_src[k] - trial;
               res_in = (res_src[k] >> 1) + BIT;
            end else begin
               v_in   = v_src[k];
               res_in = res_src[k] >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               c_ff[k] <= '0;
            end else if (advance) begin
               c_ff[k] <= c_src[k];
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               v_ff[k]   <= v_in;
               res_ff[k] <= res_in;
            end
         end
      end
   endgenerate

   assign ctrl_out = c_ff[STEPS-1];
   assign root_out = res_ff[STEPS-1][30:0];

endmodule
`default_nettype wire

// ----- rtl/squared_gaussian_illumination.sv -----
`default_nettype none
// Squared-gaussian illumination: for each pixel (world_x, world_y, inside_aperture) the block
// returns amplitude * sqrt(1 - (1 - exp(-r2 * inv_width2))^2) in signed Q16.16, where r2 is the
// squared distance from (center_x, center_y); pixels outside the aperture give zero. It takes
// one pixel per clock, unless held as described below, through 127 register stages. That depth
// comes from nine front-end stages, the 20-term exp series (four stages per term: a split
// 61x60 multiply and an exact divide by the term index), four back-end stages, the 32-stage
// square root and the product and output registers. The whole pipeline holds only while the
// output register is full and not taken and the last stage holds an item.
// The stages read the configuration registers at different depths, so write them through the
// csr_ port only while no pixel is in flight.
`include "squared_gaussian_illumination_defines.svh"
module squared_gaussian_illumination import sgi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_world_x,
   input  logic signed [23:0] req_world_y,
   input  logic               req_inside_aperture,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_illumination,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic signed [31:0] amplitude_ff;
   logic [31:0]        inv_width2_ff;
   logic [23:0]        center_x_ff;
   logic [23:0]        center_y_ff;

   logic               advance;
   logic               rsp_load;

   sgi_ctrl_type ca_in, ca_ff, cb_ff, cc_ff, cd_ff, ce_ff, cg_in, cg_ff;
   sgi_ctrl_type ch_ff, ci_ff, cj_in, cj_ff;
   sgi_ctrl_type ck_ff, cl_ff, cm_ff, co_ff, cp_ff;

   logic signed [24:0] dx_in, dy_in, dx_ff, dy_ff;
   logic signed [49:0] sqx_in, sqy_in;
   logic [47:0]        sqx_ff, sqy_ff;
   logic [48:0]        r2_ff;
   logic [63:0]        pl_ff;
   logic [48:0]        ph_ff;
   logic [49:0]        x_ff;
   logic [62:0]        xm_ff;
   logic [29:0]        xs_g_ff, xs_h_ff;
   logic [6:0]         nest_in, nest_h_ff, nest_i_ff;
   logic [62:0]        nl_ff;
   logic [61:0]        rem_full;
   logic [56:0]        rem_ff;
   logic               rem_ge;
   logic [56:0]        remf;
   logic [6:0]         n_fix;
   logic [59:0]        f_in, f_ff;

   logic [60:0]        chain_term [TAYLOR_TERMS+1];
   logic [60:0]        chain_sum  [TAYLOR_TERMS+1];
   logic [59:0]        chain_f    [TAYLOR_TERMS+1];
   sgi_ctrl_type       chain_ctrl [TAYLOR_TERMS+1];

   logic [60:0]        sumf_ff;
   logic [60:0]        u_ff;
   logic [56:0]        uu_hh_ff;
   logic [60:0]        uu_hl_ff;
   logic [60:0]        uu_lh_ff;
   logic [63:0]        uu_ll_ff;
   logic [120:0]       uu_full;
   logic [60:0]        h_ff;

   sgi_ctrl_type       root_ctrl;
   logic [30:0]        root_s;
   logic signed [31:0] s_ext;
   logic signed [63:0] prod_in;
   logic signed [62:0] prod_ff;
   logic signed [62:0] rnd_full;
   logic signed [32:0] rnd;
   logic signed [31:0] sat;
   logic signed [31:0] rsp_illumination_ff;
   logic               rsp_valid_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff  <= AMPLITUDE_RESET;
         inv_width2_ff <= INV_WIDTH2_RESET;
         center_x_ff   <= CENTER_RESET;
         center_y_ff   <= CENTER_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_AMPLITUDE:  amplitude_ff  <= csr_data;
            REG_INV_WIDTH2: inv_width2_ff <= csr_data;
            REG_CENTER_X:   center_x_ff   <= csr_data[23:0];
            REG_CENTER_Y:   center_y_ff   <= csr_data[23:0];
         endcase
      end
   end

   // Hold the pipeline only when the output is blocked and the last stage is full
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign advance   = rsp_load || !cp_ff.valid;
   assign req_ready = advance;

   // Front-end next values
   assign ca_in  = '{valid: req_valid, zero: ~req_inside_aperture, n: 6'd0};
   assign dx_in  = {req_world_x[23], req_world_x} - {center_x_ff[23], center_x_ff};
   assign dy_in  = {req_world_y[23], req_world_y} - {center_y_ff[23], center_y_ff};
   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;

   always_comb begin
      cg_in      = ce_ff;
      cg_in.zero = ce_ff.zero | (x_ff >= X_LIMIT);
   end

   assign nest_in  = xm_ff[62:56];
   assign rem_full = {xs_h_ff, 32'd0} - nl_ff[61:0];
   assign rem_ge   = rem_ff >= 57'(LN2_Q56);
   assign remf     = rem_ge ? rem_ff - 57'(LN2_Q56) : rem_ff;
   assign n_fix    = nest_i_ff + 7'(rem_ge);
   assign f_in     = {remf[55:0], 4'd0};

   always_comb begin
      cj_in      = ci_ff;
      cj_in.n    = n_fix[5:0];
      cj_in.zero = ci_ff.zero | (n_fix >= N_LIMIT);
   end

   // Advance front-end control
   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= '0;
         cb_ff <= '0;
         cc_ff <= '0;
         cd_ff <= '0;
         ce_ff <= '0;
         cg_ff <= '0;
         ch_ff <= '0;
         ci_ff <= '0;
         cj_ff <= '0;
      end else if (advance) begin
         ca_ff <= ca_in;
         cb_ff <= ca_ff;
         cc_ff <= cb_ff;
         cd_ff <= cc_ff;
         ce_ff <= cd_ff;
         cg_ff <= cg_in;
         ch_ff <= cg_ff;
         ci_ff <= ch_ff;
         cj_ff <= cj_in;
      end
   end

   // Front end: distance, scaled radius, split into n*ln2 + f
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         sqx_ff    <= sqx_in[47:0];
         sqy_ff    <= sqy_in[47:0];
         r2_ff     <= 49'(sqx_ff) + 49'(sqy_ff);
         pl_ff     <= r2_ff[31:0] * inv_width2_ff;
         ph_ff     <= r2_ff[48:32] * inv_width2_ff;
         x_ff      <= 50'(ph_ff) + 50'(pl_ff[63:32]);
         xm_ff     <= x_ff[29:0] * LOG2E_Q32;
         xs_g_ff   <= x_ff[29:0];
         nest_h_ff <= nest_in;
         nl_ff     <= 63'(nest_in) * 63'(LN2_Q56);
         xs_h_ff   <= xs_g_ff;
         rem_ff    <= rem_full[56:0];
         nest_i_ff <= nest_h_ff;
         f_ff      <= f_in;
      end
   end

   // Exp series, one term block per index
   assign chain_ctrl[0] = cj_ff;
   assign chain_term[0] = ONE_Q60;
   assign chain_sum[0]  = ONE_Q60;
   assign chain_f[0]    = f_ff;

   generate
      for (genvar t = 1; t <= TAYLOR_TERMS; t++) begin : g_term
         sgi_term #(
            .IDX (t)
         ) u_term (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .ctrl_in  (chain_ctrl[t-1]),
            .term_in  (chain_term[t-1]),
            .sum_in   (chain_sum[t-1]),
            .f_in     (chain_f[t-1]),
            .ctrl_out (chain_ctrl[t]),
            .term_out (chain_term[t]),
            .sum_out  (chain_sum[t]),
            .f_out    (chain_f[t])
         );
      end
   endgenerate

   // Back end: last term, scale by 2^-n, form 1 - (1 - g)^2
   assign uu_full = 121'({uu_hh_ff, 64'd0}) + 121'({uu_hl_ff, 32'd0})
                  + 121'({uu_lh_ff, 32'd0}) + 121'(uu_ll_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ck_ff <= '0;
         cl_ff <= '0;
         cm_ff <= '0;
         co_ff <= '0;
         cp_ff <= '0;
      end else if (advance) begin
         ck_ff <= chain_ctrl[TAYLOR_TERMS];
         cl_ff <= ck_ff;
         cm_ff <= cl_ff;
         co_ff <= cm_ff;
         cp_ff <= root_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sumf_ff  <= chain_sum[TAYLOR_TERMS] + chain_term[TAYLOR_TERMS];
         u_ff     <= ONE_Q60 - (sumf_ff >> ck_ff.n);
         uu_hh_ff <= u_ff[60:32] * u_ff[60:32];
         uu_hl_ff <= u_ff[60:32] * u_ff[31:0];
         uu_lh_ff <= u_ff[60:32] * u_ff[31:0];
         uu_ll_ff <= u_ff[31:0] * u_ff[31:0];
         h_ff     <= ONE_Q60 - uu_full[120:60];
         prod_ff  <= prod_in[62:0];
      end
   end

   sgi_root u_root (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctrl_in  (co_ff),
      .h_in     (h_ff),
      .ctrl_out (root_ctrl),
      .root_out (root_s)
   );

   // Amplitude product, then round to nearest and saturate
   assign s_ext    = $signed({1'b0, root_s});
   assign prod_in  = amplitude_ff * s_ext;
   assign rnd_full = prod_ff + 63'sd536870912;
   assign rnd      = rnd_full[62:30];

   always_comb begin
      if (rnd > 33'sd2147483647) begin
         sat = 32'sh7FFFFFFF;
      end else if (rnd < -33'sd2147483648) begin
         sat = 32'sh80000000;
      end else begin
         sat = rnd[31:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= cp_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_illumination_ff <= cp_ff.zero ? 32'sd0 : sat;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_illumination = rsp_illumination_ff;

   `SGI_ASSERT_NEXT(a_no_invented_item, clock, reset, rsp_load && !cp_ff.valid, !rsp_valid)
   `SGI_ASSERT_NEXT(a_zero_result, clock, reset, rsp_load && cp_ff.valid && cp_ff.zero, rsp_illumination == 32'sd0)
   `SGI_ASSERT_IMPLY(a_root_range, clock, reset, root_ctrl.valid, root_s <= 31'd1073741824)

endmodule
`default_nettype wire
